// ===== rtl/autorange_current_averager_top_assert.svh =====
// Assertion macros used by the checker file of the averager.
`ifndef AUTORANGE_CURRENT_AVERAGER_TOP_ASSERT_SVH
`define AUTORANGE_CURRENT_AVERAGER_TOP_ASSERT_SVH

// A property checked at every rising clock edge outside reset.
`define ACA_ASSERT_IMPL(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("averager port check failed");

// A condition that must be followed by another in the next cycle.
`define ACA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    `ACA_ASSERT_IMPL(lbl, clk, rst_n, (ante) |=> (cons))

`endif

// ===== rtl/aca_pkg.sv =====
package aca_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int FIELD_W         = 12;
    localparam int VALUE_W         = 24;
    localparam int RANGE_W         = 2;
    localparam int MODE_W          = 2;
    localparam int CAL_W           = 12;
    localparam int COEF_W          = 30;
    localparam int MUL_W           = 32;
    localparam int SUM_W           = 32;
    localparam int COUNT_W         = 7;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 12;

    typedef struct packed {
        logic [FIELD_W-1:0] sample_low_gain;
        logic [FIELD_W-1:0] sample_mid_gain;
        logic [FIELD_W-1:0] sample_high_gain;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0] current_value;
        logic [FIELD_W-1:0] raw_low;
        logic [FIELD_W-1:0] raw_mid;
        logic [FIELD_W-1:0] raw_high;
        logic [RANGE_W-1:0] range_used;
    } t_out_item;

    typedef struct packed {
        logic [MODE_W-1:0]  average_mode;
        logic [FIELD_W-1:0] range_threshold;
        logic [CAL_W-1:0]   cal_high_gain;
        logic [CAL_W-1:0]   cal_mid_gain;
        logic [CAL_W-1:0]   cal_low_gain;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic mul_coef;
        logic scale;
        logic acc;
        logic mean;
        logic emit;
        logic emit_held;
    } t_dp_cmd;

    typedef struct packed {
        logic emit_now;
        logic win_close;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/autorange_current_averager_top.sv =====
// Autoranging current averager.
// Input channel: one transfer carries the three amplifier samples of one tick
// (i_in_valid, o_in_stall, i_in_data). Output channel: one transfer carries a
// scaled current with the raw samples and the range used (o_out_valid,
// i_out_stall, o_out_data). Registers are written on the configuration port
// (i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data); the user must do so only
// while the block is idle, as the block does not enforce it. An item passes the
// load, coefficient, scale and accumulate steps, and a mean step when it closes
// an averaging window: the samples, calibration, coefficient and reciprocal
// products all go through a single 32 by 32 multiplier, one product per cycle,
// and o_in_stall is high while an item is in work. In the averaging modes only
// the item closing a window produces a result. A result waits in the output
// register; if the receiver stalls and the next result is ready too, the block
// holds that result and stalls its input until the output register frees.
// Reset clears the window sum and count, empties the output register and sets
// the registers to their reset values; the block accepts an item directly after.
module autorange_current_averager_top import aca_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg     cfg;
    t_dp_cmd  cmd;
    t_dp_stat stat;

    aca_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    aca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    aca_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== rtl/aca_cfg.sv =====
module aca_cfg import aca_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_cfg_ready,
    output t_cfg                  o_cfg
);

    localparam logic [CFG_IDX_W-1:0] IDX_AVERAGE_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] IDX_RANGE_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] IDX_CAL_HIGH_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] IDX_CAL_MID_GAIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] IDX_CAL_LOW_GAIN    = 3'd4;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                IDX_AVERAGE_MODE:    n_cfg.average_mode    = i_cfg_data[MODE_W-1:0];
                IDX_RANGE_THRESHOLD: n_cfg.range_threshold = i_cfg_data[FIELD_W-1:0];
                IDX_CAL_HIGH_GAIN:   n_cfg.cal_high_gain   = i_cfg_data[CAL_W-1:0];
                IDX_CAL_MID_GAIN:    n_cfg.cal_mid_gain    = i_cfg_data[CAL_W-1:0];
                IDX_CAL_LOW_GAIN:    n_cfg.cal_low_gain    = i_cfg_data[CAL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.average_mode    <= '0;
            r_cfg.range_threshold <= 12'd2000;
            r_cfg.cal_high_gain   <= 12'd1000;
            r_cfg.cal_mid_gain    <= 12'd1000;
            r_cfg.cal_low_gain    <= 12'd1000;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

endmodule

// ===== rtl/aca_ctrl.sv =====
module aca_ctrl import aca_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output logic     o_in_stall,
    output t_dp_cmd  o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_COEF  = 3'd1;
    localparam logic [2:0] ST_SCALE = 3'd2;
    localparam logic [2:0] ST_ACC   = 3'd3;
    localparam logic [2:0] ST_MEAN  = 3'd4;
    localparam logic [2:0] ST_WAIT  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_COEF;
                end
            end
            ST_COEF: begin
                o_cmd.mul_coef = 1'b1;
                n_state        = ST_SCALE;
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                if (i_stat.emit_now) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit = 1'b1;
                        n_state    = ST_IDLE;
                    end else begin
                        n_state = ST_WAIT;
                    end
                end else if (i_stat.win_close) begin
                    n_state = ST_MEAN;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_MEAN: begin
                o_cmd.mean = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end else begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_held = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

// ===== rtl/aca_dp.sv =====
module aca_dp import aca_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_in_item  i_in_data,
    input  t_dp_cmd   i_cmd,
    input  logic      i_out_stall,
    output t_dp_stat  o_stat,
    output logic      o_out_valid,
    output t_out_item o_out_data
);

    localparam int SW           = (SAMPLE_BITS < FIELD_W) ? SAMPLE_BITS : FIELD_W;
    localparam int P_W          = SW + CAL_W;
    localparam int Q_W          = SW + CAL_W + COEF_W;
    localparam int SCALE_SHIFT  = 23;
    localparam int T_W          = Q_W - SCALE_SHIFT;
    localparam int MEAN_IN_W    = SUM_W - 1;

    localparam logic [COEF_W-1:0] COEF_GAIN1   = 30'd845006300;
    localparam logic [COEF_W-1:0] COEF_GAIN40  = 30'd21125157;
    localparam logic [COEF_W-1:0] COEF_GAIN391 = 30'd2161141;

    // Exact reciprocals: floor(x * M / 2^S) equals floor(x / d) for x below 2^31.
    localparam logic [MUL_W-1:0] RECIP_125       = 32'd2199023256;
    localparam int               RECIP_125_SHIFT = 38;
    localparam logic [MUL_W-1:0] RECIP_5         = 32'd3435973837;
    localparam int               RECIP_5_SHIFT   = 34;
    localparam logic [MUL_W-1:0] RECIP_25        = 32'd2748779070;
    localparam int               RECIP_25_SHIFT  = 36;

    // Scaled values of 2^24 and above: (2^24 * 1000 * 2^20) / 2^23.
    localparam logic [63:0]        SAT_LIMIT = 64'd2097152000;
    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

    localparam logic [MODE_W-1:0]  MODE_EVERY   = 2'd0;
    localparam logic [MODE_W-1:0]  MODE_MEAN10  = 2'd1;
    localparam logic [MODE_W-1:0]  MODE_MEAN100 = 2'd2;

    localparam logic [RANGE_W-1:0] RANGE_HIGH = 2'd0;
    localparam logic [RANGE_W-1:0] RANGE_MID  = 2'd1;
    localparam logic [RANGE_W-1:0] RANGE_LOW  = 2'd2;

    logic [SW-1:0]      s_low;
    logic [SW-1:0]      s_mid;
    logic [SW-1:0]      s_high;
    logic [SW-1:0]      sel_sample;
    logic [CAL_W-1:0]   sel_cal;
    logic [RANGE_W-1:0] sel_range;
    logic [COEF_W-1:0]  coef;

    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [2*MUL_W-1:0] mul_p;

    logic [T_W-1:0]     scale_t;
    logic               scale_sat;

    logic [SUM_W-1:0]   acc_base;
    logic [SUM_W-1:0]   acc_sum;
    logic [COUNT_W-1:0] cnt_inc;
    logic [14:0]        m10_p;
    logic [3:0]         m10_q;
    logic [COUNT_W-1:0] cnt_mod10;
    logic [COUNT_W-1:0] cnt_mod100;
    logic [COUNT_W-1:0] cnt_avg;
    logic               mode_avg;

    logic [MEAN_IN_W-1:0] mean_in;
    logic [SUM_W-1:0]     mean_q;
    logic [VALUE_W-1:0]   mean_sat;
    logic [VALUE_W-1:0]   res_live;
    logic                 out_free;

    logic [SW-1:0]      r_raw_low;
    logic [SW-1:0]      r_raw_mid;
    logic [SW-1:0]      r_raw_high;
    logic [RANGE_W-1:0] r_range;
    logic [P_W-1:0]     r_p;
    logic [Q_W-1:0]     r_q;
    logic [VALUE_W-1:0] r_value;
    logic [VALUE_W-1:0] r_res;
    logic [SUM_W-1:0]   r_sum;
    logic [COUNT_W-1:0] r_count;
    logic               r_out_valid;
    t_out_item          r_out;

    // Only the low sample bits are meaningful.
    assign s_low  = i_in_data.sample_low_gain[SW-1:0];
    assign s_mid  = i_in_data.sample_mid_gain[SW-1:0];
    assign s_high = i_in_data.sample_high_gain[SW-1:0];

    always_comb begin
        if (FIELD_W'(s_high) < i_cfg.range_threshold) begin
            sel_sample = s_high;
            sel_cal    = i_cfg.cal_high_gain;
            sel_range  = RANGE_HIGH;
        end else if (FIELD_W'(s_mid) < i_cfg.range_threshold) begin
            sel_sample = s_mid;
            sel_cal    = i_cfg.cal_mid_gain;
            sel_range  = RANGE_MID;
        end else begin
            sel_sample = s_low;
            sel_cal    = i_cfg.cal_low_gain;
            sel_range  = RANGE_LOW;
        end
    end

    always_comb begin
        case (r_range)
            RANGE_HIGH: coef = COEF_GAIN391;
            RANGE_MID:  coef = COEF_GAIN40;
            RANGE_LOW:  coef = COEF_GAIN1;
            default:    coef = COEF_GAIN1;
        endcase
    end

    assign scale_t   = T_W'(r_q >> SCALE_SHIFT);
    assign scale_sat = (64'(scale_t) >= SAT_LIMIT);

    assign mode_avg = (i_cfg.average_mode == MODE_MEAN10) ||
                      (i_cfg.average_mode == MODE_MEAN100);

    // The window sum divides by 10 or 100 as a halving or quartering followed
    // by a reciprocal multiplication by 5 or 25.
    assign mean_in = (i_cfg.average_mode == MODE_MEAN100) ? MEAN_IN_W'(r_sum >> 2)
                                                          : r_sum[SUM_W-1:1];

    // One shared multiplier, stepped through the stages of the calculation.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (i_cmd.load) begin
            mul_a = MUL_W'(sel_sample);
            mul_b = MUL_W'(sel_cal);
        end else if (i_cmd.mul_coef) begin
            mul_a = MUL_W'(r_p);
            mul_b = MUL_W'(coef);
        end else if (i_cmd.scale) begin
            mul_a = MUL_W'(scale_t);
            mul_b = RECIP_125;
        end else if (i_cmd.mean) begin
            mul_a = MUL_W'(mean_in);
            mul_b = (i_cfg.average_mode == MODE_MEAN100) ? RECIP_25 : RECIP_5;
        end
    end

    assign mul_p = mul_a * mul_b;

    assign mean_q   = (i_cfg.average_mode == MODE_MEAN100) ? SUM_W'(mul_p >> RECIP_25_SHIFT)
                                                           : SUM_W'(mul_p >> RECIP_5_SHIFT);
    assign mean_sat = (mean_q > SUM_W'(VALUE_MAX)) ? VALUE_MAX : mean_q[VALUE_W-1:0];

    // A count of zero opens a new window, so the old sum is dropped.
    assign acc_base = (r_count == '0) ? '0 : r_sum;
    assign acc_sum  = acc_base + SUM_W'(r_value);
    assign cnt_inc  = r_count + COUNT_W'(1);

    // The count never exceeds 100 here, so 205/2048 gives the exact tenth.
    assign m10_p      = 15'(cnt_inc) * 15'd205;
    assign m10_q      = m10_p[14:11];
    assign cnt_mod10  = cnt_inc - (COUNT_W'(m10_q) * COUNT_W'(10));
    assign cnt_mod100 = (cnt_inc >= COUNT_W'(100)) ? cnt_inc - COUNT_W'(100) : cnt_inc;
    assign cnt_avg    = (i_cfg.average_mode == MODE_MEAN10) ? cnt_mod10 : cnt_mod100;

    assign res_live = i_cmd.mean ? mean_sat : r_value;
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_stat.emit_now  = (i_cfg.average_mode == MODE_EVERY);
    assign o_stat.win_close = mode_avg && (cnt_avg == '0);
    assign o_stat.out_free  = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.acc) begin
                case (i_cfg.average_mode)
                    MODE_EVERY: begin
                        r_sum   <= '0;
                        r_count <= '0;
                    end
                    MODE_MEAN10, MODE_MEAN100: begin
                        r_sum   <= acc_sum;
                        r_count <= cnt_avg;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.emit || i_cmd.emit_held) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_raw_low  <= s_low;
            r_raw_mid  <= s_mid;
            r_raw_high <= s_high;
            r_range    <= sel_range;
            r_p        <= mul_p[P_W-1:0];
        end
        if (i_cmd.mul_coef) begin
            r_q <= mul_p[Q_W-1:0];
        end
        if (i_cmd.scale) begin
            r_value <= scale_sat ? VALUE_MAX : mul_p[RECIP_125_SHIFT +: VALUE_W];
        end
        if (i_cmd.acc || i_cmd.mean) begin
            r_res <= res_live;
        end
        if (i_cmd.emit || i_cmd.emit_held) begin
            r_out.current_value <= i_cmd.emit ? res_live : r_res;
            r_out.raw_low       <= FIELD_W'(r_raw_low);
            r_out.raw_mid       <= FIELD_W'(r_raw_mid);
            r_out.raw_high      <= FIELD_W'(r_raw_high);
            r_out.range_used    <= r_range;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/aca_checker.sv =====
`include "autorange_current_averager_top_assert.svh"

module aca_checker import aca_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input t_out_item             o_out_data
);

    // A stalled result stays offered unchanged.
    `ACA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

    // An accepted item keeps the input stalled through its coefficient, scale and accumulate steps.
    `ACA_ASSERT_NEXT(a_busy_after_transfer, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall ##1 o_in_stall ##1 o_in_stall)

    // A new result only appears at the end of an item's work.
    `ACA_ASSERT_IMPL(a_result_from_work, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(o_in_stall))

endmodule

bind autorange_current_averager_top aca_checker u_aca_checker (.*);
